// ===== hdl/krc_pkg.sv =====
package krc_pkg;

  localparam int unsigned CylW      = 4;
  localparam int unsigned LevelW    = 15;
  localparam int unsigned GainW     = 13;
  localparam int unsigned TimingW   = 14;
  localparam int unsigned ThrottleW = 10;
  localparam int unsigned RetardW   = 13;
  localparam int unsigned TrimW     = 12;
  localparam int unsigned CountW    = 32;
  localparam int unsigned AggrW     = 7;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam int TimingFloor = 2000;
  localparam int FuelPctCap  = 30;
  localparam int FuelTrimMax = 3000;

  // floor(x / 100) == (x * Div100Mul) >> Div100Shift for x < 2^21
  localparam int unsigned Div100Mul   = 2684355;
  localparam int unsigned Div100Shift = 28;

  typedef enum logic [0:0] {
    OpKnock = 1'b0,
    OpTick  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    RegRetardAggr  = 3'd0,
    RegFuelAggr    = 3'd1,
    RegFuelPct     = 3'd2,
    RegRetardDecay = 3'd3,
    RegFuelDecay   = 3'd4,
    RegMinThrottle = 3'd5
  } reg_idx_e;

endpackage

// ===== hdl/krc_if.sv =====
interface krc_item_if import krc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  opcode_e                     opcode;
  logic [CylW-1:0]             cylinder;
  logic signed [LevelW-1:0]    knock_level;
  logic signed [GainW-1:0]     cylinder_gain;
  logic signed [TimingW-1:0]   base_timing;
  logic [ThrottleW-1:0]        throttle;
  logic signed [LevelW-1:0]    new_threshold;
  logic [RetardW-1:0]          new_max_retard;

  modport source (output valid, opcode, cylinder, knock_level, cylinder_gain, base_timing,
                  throttle, new_threshold, new_max_retard, input ready);
  modport sink   (input valid, opcode, cylinder, knock_level, cylinder_gain, base_timing,
                  throttle, new_threshold, new_max_retard, output ready);
endinterface

interface krc_result_if import krc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_knock;
  logic [CylW-1:0]    cylinder_echo;
  logic [RetardW-1:0] retard;
  logic [TrimW-1:0]   fuel_trim;
  logic [CountW-1:0]  knock_total;
  logic               retard_active;

  modport source (output valid, is_knock, cylinder_echo, retard, fuel_trim, knock_total,
                  retard_active, input ready);
  modport sink   (input valid, is_knock, cylinder_echo, retard, fuel_trim, knock_total,
                  retard_active, output ready);
endinterface

// ===== hdl/knock_retard_controller_core.sv =====
// knock retard controller
// item channel req_i: opcode 0 is a knock event (level, gain, timing, cylinder),
// opcode 1 is a periodic tick (throttle, new threshold, new maximum retard).
// result channel rsp_o: one result per item with the knock flag, the cylinder
// (zero for ticks) and the retard, fuel trim and knock count after the update.
// registers sit on an apb port (psel, penable, pwrite, paddr, pwdata, prdata,
// pready), register n at byte address 4*n; write them only while idle.
// an item passes the stages in order: one stage forms the retard product, one
// divides it by 100 with a reciprocal multiplier, and the last updates the
// accumulators and loads the result register.
// throughput is one item per clock while not stalled. when the receiver stalls,
// all three stages hold and ready drops as soon as the result register is full
// and not taken, so up to two items wait in the first two stages behind it.
// reset (rst_ni low, asynchronous) clears retard, trim, knock count, threshold
// and maximum retard, empties the pipeline and loads the register defaults.
module knock_retard_controller_core import krc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  krc_item_if.sink            req_i,
  krc_result_if.source        rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  typedef struct packed {
    opcode_e                   opcode;
    logic [CylW-1:0]           cylinder;
    logic signed [LevelW:0]    level;
    logic [ThrottleW-1:0]      throttle;
    logic signed [LevelW-1:0]  new_threshold;
    logic [RetardW-1:0]        new_max_retard;
    logic [TrimW-1:0]          fuel_step;
  } item_t;

  // configuration
  logic [AggrW-1:0]     retard_aggr_q, fuel_aggr_q, fuel_pct_q;
  logic [RetardW-1:0]   retard_decay_q;
  logic [TrimW-1:0]     fuel_decay_q;
  logic [ThrottleW-1:0] min_throttle_q;
  logic                 cfg_we;
  reg_idx_e             cfg_idx;

  // pipeline
  logic         en;
  logic         v1_q, v2_q, out_valid_q;
  item_t        it1_d, it1_q, it2_q;
  logic signed [23:0] prod_d, prod_q;
  logic [20:0]  mag;
  logic [42:0]  qprod;
  logic [13:0]  quot_q;
  logic         neg_q;

  // state
  logic [RetardW-1:0]       retard_q, retard_d;
  logic [TrimW-1:0]         fuel_q, fuel_d;
  logic [CountW-1:0]        count_q, count_d;
  logic signed [LevelW-1:0] thr_q, thr_d;
  logic [RetardW-1:0]       max_q, max_d;
  logic                     knock_q, knock_d;
  logic [CylW-1:0]          echo_q, echo_d;

  logic signed [15:0] timing_span;
  logic [AggrW-1:0]   pct_cap;
  logic signed [14:0] step;
  logic signed [16:0] rsum;
  logic [13:0]        fsum;
  logic signed [13:0] rdec;
  logic signed [12:0] fdec;

  // apb
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegRetardAggr:  prdata = ApbDataW'(retard_aggr_q);
      RegFuelAggr:    prdata = ApbDataW'(fuel_aggr_q);
      RegFuelPct:     prdata = ApbDataW'(fuel_pct_q);
      RegRetardDecay: prdata = ApbDataW'(retard_decay_q);
      RegFuelDecay:   prdata = ApbDataW'(fuel_decay_q);
      RegMinThrottle: prdata = ApbDataW'(min_throttle_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retard_aggr_q  <= AggrW'(20);
      fuel_aggr_q    <= '0;
      fuel_pct_q     <= '0;
      retard_decay_q <= RetardW'(10);
      fuel_decay_q   <= '0;
      min_throttle_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegRetardAggr:  retard_aggr_q  <= pwdata[AggrW-1:0];
        RegFuelAggr:    fuel_aggr_q    <= pwdata[AggrW-1:0];
        RegFuelPct:     fuel_pct_q     <= pwdata[AggrW-1:0];
        RegRetardDecay: retard_decay_q <= pwdata[RetardW-1:0];
        RegFuelDecay:   fuel_decay_q   <= pwdata[TrimW-1:0];
        RegMinThrottle: min_throttle_q <= pwdata[ThrottleW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // stage 1: level sum, retard product, fuel step
  assign timing_span = 16'(req_i.base_timing) + 16'(TimingFloor);
  assign prod_d      = timing_span * $signed({1'b0, retard_aggr_q});
  assign pct_cap = (fuel_pct_q < AggrW'(FuelPctCap)) ? fuel_pct_q : AggrW'(FuelPctCap);

  always_comb begin
    it1_d.opcode         = req_i.opcode;
    it1_d.cylinder       = req_i.cylinder;
    it1_d.level          = (LevelW+1)'(req_i.knock_level) + (LevelW+1)'(req_i.cylinder_gain);
    it1_d.throttle       = req_i.throttle;
    it1_d.new_threshold  = req_i.new_threshold;
    it1_d.new_max_retard = req_i.new_max_retard;
    it1_d.fuel_step      = TrimW'(pct_cap * fuel_aggr_q);
  end

  // stage 2: divide magnitude by 100
  assign mag   = prod_q[23] ? 21'(-prod_q) : prod_q[20:0];
  assign qprod = 43'(mag) * 43'(Div100Mul);

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q  <= it1_d;
      prod_q <= prod_d;
      it2_q  <= it1_q;
      quot_q <= qprod[Div100Shift+13:Div100Shift];
      neg_q  <= prod_q[23];
    end
  end

  // stage 3: accumulator update
  assign step = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
  assign rsum = $signed({4'b0, retard_q}) + 17'(step);
  assign fsum = 14'(fuel_q) + 14'(it2_q.fuel_step);
  assign rdec = $signed({1'b0, retard_q}) - $signed({1'b0, retard_decay_q});
  assign fdec = $signed({1'b0, fuel_q}) - $signed({1'b0, fuel_decay_q});

  always_comb begin
    retard_d = retard_q;
    fuel_d   = fuel_q;
    count_d  = count_q;
    thr_d    = thr_q;
    max_d    = max_q;
    knock_d  = 1'b0;
    echo_d   = '0;
    if (it2_q.opcode == OpKnock) begin
      echo_d = it2_q.cylinder;
      if (it2_q.level > (LevelW+1)'(thr_q)) begin
        knock_d = 1'b1;
        count_d = count_q + 1'b1;
        if (rsum < 0) begin
          retard_d = '0;
        end else if (rsum > $signed({4'b0, max_q})) begin
          retard_d = max_q;
        end else begin
          retard_d = rsum[RetardW-1:0];
        end
        fuel_d = (fsum > 14'(FuelTrimMax)) ? TrimW'(FuelTrimMax) : fsum[TrimW-1:0];
      end
    end else if (it2_q.throttle < min_throttle_q) begin
      retard_d = '0;
      fuel_d   = '0;
    end else begin
      retard_d = (rdec < 0) ? '0 : rdec[RetardW-1:0];
      fuel_d   = (fdec < 0) ? '0 : fdec[TrimW-1:0];
      thr_d    = it2_q.new_threshold;
      max_d    = it2_q.new_max_retard;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      retard_q    <= '0;
      fuel_q      <= '0;
      count_q     <= '0;
      thr_q       <= '0;
      max_q       <= '0;
      knock_q     <= 1'b0;
      echo_q      <= '0;
    end else if (en) begin
      v1_q        <= req_i.valid;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
      if (v2_q) begin
        retard_q <= retard_d;
        fuel_q   <= fuel_d;
        count_q  <= count_d;
        thr_q    <= thr_d;
        max_q    <= max_d;
        knock_q  <= knock_d;
        echo_q   <= echo_d;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.is_knock      = knock_q;
  assign rsp_o.cylinder_echo = echo_q;
  assign rsp_o.retard        = retard_q;
  assign rsp_o.fuel_trim     = fuel_q;
  assign rsp_o.knock_total   = count_q;
  assign rsp_o.retard_active = |retard_q;

endmodule
